/* design/zts_pkg.sv */
// Package for the Zipf table sampler: shared constants, command and status types.
// No dependencies.
package zts_pkg;

  // Number of range table entries
  localparam int MaxRanges = 4096;

  localparam logic [63:0] MixMulA = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] MixMulB = 64'h165667B19E3779F9;

  // Last mix step: three xor-shifts plus two multiplies of three steps each
  localparam logic [3:0] MixLastStep = 4'd8;

  localparam logic [1:0] ModeUniform  = 2'd0;
  localparam logic [1:0] ModePermuted = 2'd1;

  localparam logic [1:0] CfgMode  = 2'd0;
  localparam logic [1:0] CfgBound = 2'd1;
  localparam logic [1:0] CfgCount = 2'd2;

  // Operand selects for the shared divider
  typedef enum logic [1:0] {
    DIV_OFFSET_BOUND,
    DIV_OFFSET_SIZE,
    DIV_MIX_BOUND
  } div_sel_e;

  typedef struct packed {
    logic     load_wr;     // write table entry from request
    logic     capture;     // latch request words
    logic     srch_init;   // set search bounds
    logic     srch_rd;     // read threshold at mid
    logic     srch_step;   // update bounds with read data
    logic     ent_rd;      // read start/size at lo
    logic     div_start;
    div_sel_e div_sel;
    logic     rank_form;   // rank = rem (or 0) + start
    logic     mix_step;    // advance one mix stage
    logic     mix_init;
    logic     res_load;    // output value from divider
    logic     res_rank;    // output value is rank
  } zts_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic srch_done;
  } zts_sts_t;

endpackage

/* design/zts_if.sv */
// Valid/ready channel interface with payload type parameter.
// Depends on nothing.
interface zts_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/zts_div.sv */
// Radix-2 restoring divider, 64-bit unsigned, one quotient bit per cycle.
// Uses zts_pkg for nothing but house style; a zero divisor returns the dividend.
module zts_div import zts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] rem_o
);
  logic [63:0] quo_q, quo_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] dsr_q, dsr_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        zero_q, zero_d;
  logic [64:0] shifted;
  logic [64:0] diff;

  assign shifted = {rem_q[63:0], quo_q[63]};
  assign diff    = shifted - {1'b0, dsr_q};

  // Shift in one dividend bit and try a subtract each cycle while busy
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    zero_d = zero_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
      zero_d = (divisor_i == '0);
    end else if (busy_q) begin
      quo_d = {quo_q[62:0], 1'b0};
      if (!diff[64]) rem_d = diff;
      else           rem_d = shifted;
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    zero_q <= zero_d;
  end

  // Zero divisor leaves the dividend unchanged; keep a copy for that case
  logic [63:0] dvd_q;
  always_ff @(posedge clk_i) begin
    if (start_i) dvd_q <= dividend_i;
  end

  assign busy_o = busy_q;
  assign rem_o  = zero_q ? dvd_q : rem_q[63:0];
endmodule

/* design/zts_datapath.sv */
// Datapath: range table memory, search bounds, divider, mix stages, result.
// Depends on zts_pkg and zts_div.
module zts_datapath import zts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  zts_cmd_t    cmd_i,
  output zts_sts_t    sts_o,
  input  logic [11:0] entry_index_i,
  input  logic [63:0] entry_start_i,
  input  logic [63:0] entry_size_i,
  input  logic [63:0] entry_threshold_i,
  input  logic [63:0] pick_word_i,
  input  logic [63:0] offset_word_i,
  input  logic [63:0] upper_bound_i,
  input  logic [12:0] range_count_i,
  output logic [63:0] result_o
);
  localparam int AW = $clog2(MaxRanges);
  localparam int CW = $clog2(MaxRanges + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxRanges);

  logic [63:0] start_mem [MaxRanges];
  logic [63:0] size_mem  [MaxRanges];
  logic [63:0] thr_mem   [MaxRanges];

  logic [63:0] pick_q, offs_q;
  logic [CW-1:0] lo_q, hi_q;
  logic [63:0] thr_rd_q, start_rd_q, size_rd_q;
  logic [63:0] rank_q, mix_q, result_q;
  logic [3:0]  mix_ph_q;
  logic [CW-1:0] mid;
  logic [CW:0]   sum;
  logic          idx_ok;

  assign sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid = CW'(sum >> 1) - CW'(1);
  assign idx_ok = ({1'b0, entry_index_i} < 13'(MaxRanges));

  // Write table entries on load requests; ignore slots beyond the table
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && idx_ok) begin
      start_mem[entry_index_i[AW-1:0]] <= entry_start_i;
      size_mem[entry_index_i[AW-1:0]]  <= entry_size_i;
      thr_mem[entry_index_i[AW-1:0]]   <= entry_threshold_i;
    end
    if (cmd_i.srch_rd) thr_rd_q <= thr_mem[mid[AW-1:0]];
    if (cmd_i.ent_rd) begin
      start_rd_q <= start_mem[lo_q[AW-1:0]];
      size_rd_q  <= size_mem[lo_q[AW-1:0]];
    end
  end

  // Binary search bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else if (cmd_i.srch_init) begin
      lo_q <= '0;
      if ({3'b0, range_count_i} > 16'(MaxRanges)) hi_q <= MaxCnt;
      else hi_q <= CW'(range_count_i);
    end else if (cmd_i.srch_step) begin
      if (pick_q < thr_rd_q) hi_q <= mid + CW'(1);
      else                   lo_q <= mid + CW'(1);
    end
  end

  assign sts_o.srch_done = ({1'b0, hi_q} <= {1'b0, lo_q} + (CW+1)'(1));

  // Shared divider operand selection
  logic [63:0] dvd, dsr, rem;
  logic        busy;
  always_comb begin
    case (cmd_i.div_sel)
      DIV_OFFSET_SIZE: begin dvd = offs_q; dsr = size_rd_q;     end
      DIV_MIX_BOUND:   begin dvd = mix_q;  dsr = upper_bound_i; end
      default:         begin dvd = offs_q; dsr = upper_bound_i; end
    endcase
  end

  zts_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(cmd_i.div_start),
    .dividend_i(dvd), .divisor_i(dsr), .busy_o(busy), .rem_o(rem)
  );
  assign sts_o.div_busy = busy;

  // Mix: one xor-shift or one 32x32 partial product per step; each 64-bit
  // multiply takes three steps (low*low, low*high, high*low) into an accumulator
  logic [63:0] mix_n, acc_d, acc_q, mul_k, mul_p;
  logic [31:0] mul_x, mul_y;

  always_comb begin
    mul_k = (mix_ph_q < 4'd4) ? MixMulA : MixMulB;
    mul_x = mix_q[31:0];
    mul_y = mul_k[31:0];
    case (mix_ph_q) inside
      4'd2, 4'd6: mul_y = mul_k[63:32];
      4'd3, 4'd7: mul_x = mix_q[63:32];
      default: ;
    endcase
  end

  assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

  always_comb begin
    mix_n = mix_q;
    acc_d = acc_q;
    case (mix_ph_q) inside
      4'd0:       mix_n = mix_q ^ (mix_q >> 33);
      4'd1, 4'd5: acc_d = mul_p;
      4'd2, 4'd6: acc_d = acc_q + {mul_p[31:0], 32'd0};
      4'd3, 4'd7: mix_n = acc_q + {mul_p[31:0], 32'd0};
      4'd4:       mix_n = mix_q ^ (mix_q >> 29);
      4'd8:       mix_n = mix_q ^ (mix_q >> 32);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mix_ph_q <= '0;
    else if (cmd_i.mix_init) mix_ph_q <= '0;
    else if (cmd_i.mix_step) mix_ph_q <= mix_ph_q + 4'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pick_q <= pick_word_i;
      offs_q <= offset_word_i;
    end
    if (cmd_i.rank_form)
      rank_q <= ((size_rd_q == '0) ? 64'd0 : rem) + start_rd_q;
    if (cmd_i.mix_init) mix_q <= rank_q;
    else if (cmd_i.mix_step) mix_q <= mix_n;
    if (cmd_i.mix_step) acc_q <= acc_d;
    if (cmd_i.res_load) result_q <= rem;
    else if (cmd_i.res_rank) result_q <= rank_q;
  end

  assign result_o = result_q;
endmodule

/* design/zts_ctrl.sv */
// Controller state machine: sequences search, divides, mix and output.
// Depends on zts_pkg.
module zts_ctrl import zts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_kind_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  logic [1:0] mode_i,
  output zts_cmd_t cmd_o,
  input  zts_sts_t sts_i
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UDIV  = 4'd1;
  localparam logic [3:0] S_SRCH  = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_ERD   = 4'd4;
  localparam logic [3:0] S_RDIV0 = 4'd5;
  localparam logic [3:0] S_RDIV  = 4'd6;
  localparam logic [3:0] S_RANK  = 4'd7;
  localparam logic [3:0] S_MIX   = 4'd8;
  localparam logic [3:0] S_MDIV  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_WAIT  = 4'd11;

  logic [3:0] state_q, state_d;
  logic [1:0] mode_q, mode_d;
  logic [3:0] mcnt_q, mcnt_d;
  logic       ovld_q, ovld_d;
  logic       go;

  // Accept a new request when idle and no result is blocking
  assign in_ready_o  = (state_q == S_IDLE) && !ovld_q;
  assign out_valid_o = ovld_q;
  assign go = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    mcnt_d  = mcnt_q;
    ovld_d  = ovld_q;
    cmd_o   = '0;
    cmd_o.div_sel = DIV_OFFSET_BOUND;
    if (ovld_q && out_ready_i) ovld_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (go) begin
          cmd_o.capture = 1'b1;
          if (!in_kind_i) begin
            cmd_o.load_wr = 1'b1;
          end else begin
            mode_d = mode_i;
            if (mode_i == ModeUniform) begin
              state_d = S_UDIV;
            end else begin
              cmd_o.srch_init = 1'b1;
              state_d = S_SRCH;
            end
          end
        end
      end
      S_UDIV: begin
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        cmd_o.div_sel = (mode_q == ModeUniform) ? DIV_OFFSET_BOUND : DIV_MIX_BOUND;
        if (!sts_i.div_busy) begin
          cmd_o.res_load = 1'b1;
          state_d = S_OUT;
        end
      end
      S_SRCH: begin
        if (sts_i.srch_done) begin
          state_d = S_ERD;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd_o.srch_step = 1'b1;
        state_d = S_SRCH;
      end
      S_ERD: begin
        cmd_o.ent_rd = 1'b1;
        state_d = S_RDIV0;
      end
      S_RDIV0: begin
        cmd_o.div_sel = DIV_OFFSET_SIZE;
        cmd_o.div_start = 1'b1;
        state_d = S_RDIV;
      end
      S_RDIV: begin
        cmd_o.div_sel = DIV_OFFSET_SIZE;
        if (!sts_i.div_busy) begin
          cmd_o.rank_form = 1'b1;
          state_d = S_RANK;
        end
      end
      S_RANK: begin
        if (mode_q == ModePermuted) begin
          cmd_o.mix_init = 1'b1;
          mcnt_d = '0;
          state_d = S_MIX;
        end else begin
          cmd_o.res_rank = 1'b1;
          state_d = S_OUT;
        end
      end
      S_MIX: begin
        cmd_o.mix_step = 1'b1;
        mcnt_d = mcnt_q + 4'd1;
        if (mcnt_q == MixLastStep) state_d = S_MDIV;
      end
      S_MDIV: begin
        cmd_o.div_sel = DIV_MIX_BOUND;
        cmd_o.div_start = 1'b1;
        state_d = S_WAIT;
      end
      S_OUT: begin
        ovld_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= '0;
      mcnt_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      mcnt_q  <= mcnt_d;
      ovld_q  <= ovld_d;
    end
  end
endmodule

/* design/zipf_table_sampler.sv */
// Top level of the Zipf table sampler: config registers, controller, datapath.
// Depends on zts_pkg, zts_if, zts_ctrl, zts_datapath.
//
//  channel  dir  payload
//  in_ch    in   kind, entry_index, entry_start, entry_size, entry_threshold,
//                pick_word, offset_word
//  out_ch   out  sample_value
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// Load request: one table write. Uniform sample: one pass of the 64-step divider.
// Zipf rank: binary search over count, then a divide; permuted adds the nine mix
// steps and a second pass through the shared divider.
// One request at a time; a new one enters once the result has been taken.
// Reset clears control and config; table contents stay undefined until loaded.
module zipf_table_sampler import zts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  zts_if.sink         in_ch,
  zts_if.source       out_ch,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  logic [1:0]  mode_q;
  logic [63:0] bound_q;
  logic [12:0] count_q;
  zts_cmd_t    cmd;
  zts_sts_t    sts;

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeUniform;
      bound_q <= 64'd1;
      count_q <= 13'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMode:  mode_q  <= cfg_data_i[1:0];
        CfgBound: bound_q <= cfg_data_i;
        CfgCount: count_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  zts_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_ch.valid), .in_kind_i(in_ch.data.kind), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .mode_i(mode_q), .cmd_o(cmd), .sts_i(sts)
  );

  zts_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .sts_o(sts),
    .entry_index_i(in_ch.data.entry_index), .entry_start_i(in_ch.data.entry_start),
    .entry_size_i(in_ch.data.entry_size),
    .entry_threshold_i(in_ch.data.entry_threshold),
    .pick_word_i(in_ch.data.pick_word), .offset_word_i(in_ch.data.offset_word),
    .upper_bound_i(bound_q), .range_count_i(count_q),
    .result_o(out_ch.data.sample_value)
  );

`ifndef SYNTHESIS
  a_no_ready_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> !in_ch.ready) else $error("accepted while result pending");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped");
  a_one_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts.div_busy) else $error("divider restarted while busy");
`endif
endmodule

/* tb/testbench.sv */
// Self-checking testbench for zipf_table_sampler: directed table, then random phases.
// Depends on zts_pkg, zts_if and the zipf_table_sampler RTL.
module testbench;
  import zts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth = 4096;
  localparam int FillDepth = 256;
  localparam int SettleCycles = 300;
  localparam logic [1:0] ModeRank    = 2'd2;
  localparam logic [1:0] ModeRankAlt = 2'd3;
  localparam logic KindLoad   = 1'b0;
  localparam logic KindSample = 1'b1;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic [11:0] entry_index;
    logic [63:0] entry_start;
    logic [63:0] entry_size;
    logic [63:0] entry_threshold;
    logic [63:0] pick_word;
    logic [63:0] offset_word;
  } sample_req_t;

  typedef struct packed {
    logic [63:0] sample_value;
  } sample_rsp_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  cfg_idx;
    logic [63:0] cfg_data;
    sample_req_t req;
    bit          has_value;
    logic [63:0] value;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [63:0] cfg_data;

  zts_if #(.T(sample_req_t)) req_ch ();
  zts_if #(.T(sample_rsp_t)) rsp_ch ();

  zipf_table_sampler dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // Shadow copy of the sampler state
  logic [63:0] shadow_start [TableDepth];
  logic [63:0] shadow_size  [TableDepth];
  logic [63:0] shadow_thr   [TableDepth];
  logic [1:0]  shadow_mode;
  logic [63:0] shadow_bound;
  logic [12:0] shadow_count;

  logic [63:0] pending_values [$];
  stim_row_t   stim_rows [$];
  int          fail_count;
  int          burst_left;
  int          cycle_count;

  always #5 clk = ~clk;

  function automatic logic [63:0] mix_rank(logic [63:0] v);
    v = v ^ (v >> 33);
    v = v * MixMulA;
    v = v ^ (v >> 29);
    v = v * MixMulB;
    v = v ^ (v >> 32);
    return v;
  endfunction

  function automatic logic [63:0] mod_bound(logic [63:0] v, logic [63:0] m);
    return (m == 64'd0) ? v : v % m;
  endfunction

  // Compute the sample value from the shadow state
  function automatic logic [63:0] sample_value_of(sample_req_t r);
    int unsigned lo, hi, mid;
    logic [63:0] rank;
    if (shadow_mode == ModeUniform) return mod_bound(r.offset_word, shadow_bound);
    lo = 0;
    hi = (shadow_count > TableDepth) ? TableDepth : shadow_count;
    while (hi > lo + 1) begin
      mid = (lo + hi) / 2 - 1;
      if (r.pick_word < shadow_thr[mid]) hi = mid + 1;
      else lo = mid + 1;
    end
    rank = (shadow_size[lo] == 64'd0) ? 64'd0 : r.offset_word % shadow_size[lo];
    rank = rank + shadow_start[lo];
    if (shadow_mode == ModePermuted) return mod_bound(mix_rank(rank), shadow_bound);
    return rank;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_size();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return 64'd1;
      2: return AllOnes;
      3: return rand64();
      default: return 64'($urandom_range(2, 1000));
    endcase
  endfunction

  function automatic sample_req_t load_req(logic [11:0] idx, logic [63:0] start,
                                           logic [63:0] size, logic [63:0] thr);
    sample_req_t r;
    r = '{kind: KindLoad, entry_index: idx, entry_start: start, entry_size: size,
          entry_threshold: thr, pick_word: rand64(), offset_word: rand64()};
    return r;
  endfunction

  function automatic sample_req_t sample_req(logic [63:0] pick, logic [63:0] offset);
    sample_req_t r;
    r = '{kind: KindSample, entry_index: 12'($urandom), entry_start: rand64(),
          entry_size: rand64(), entry_threshold: rand64(), pick_word: pick,
          offset_word: offset};
    return r;
  endfunction

  function automatic void add_req(sample_req_t r, bit has_value = 0,
                                  logic [63:0] value = 64'd0);
    stim_row_t row;
    row.kind = ROW_REQ;
    row.cfg_idx = CfgMode;
    row.cfg_data = 64'd0;
    row.req = r;
    row.has_value = has_value;
    row.value = value;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [63:0] data);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.cfg_idx = idx;
    row.cfg_data = data;
    row.req = '0;
    row.has_value = 0;
    row.value = 64'd0;
    stim_rows.push_back(row);
  endfunction

  // Send one request in bursts with random gaps; record the expectation on accept
  task automatic send_request(sample_req_t r, bit has_value = 0, logic [63:0] value = 0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    forever begin
      @(posedge clk);
      if (req_ch.ready) break;
    end
    if (r.kind == KindLoad) begin
      shadow_start[r.entry_index] = r.entry_start;
      shadow_size[r.entry_index] = r.entry_size;
      shadow_thr[r.entry_index] = r.entry_threshold;
    end else begin
      pending_values.push_back(has_value ? value : sample_value_of(r));
    end
    @(negedge clk);
  endtask

  // Hold the sender until every result is back and the block is quiet
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_setting(logic [1:0] idx, logic [63:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgMode:  shadow_mode = data[1:0];
      CfgBound: shadow_bound = data;
      CfgCount: shadow_count = data[12:0];
      default: ;
    endcase
  endtask

  // Receiver stall pattern: always ready, mostly stalled, or random
  always @(negedge clk) begin
    cycle_count <= cycle_count + 1;
    case ((cycle_count / 700) % 3)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= (cycle_count % 5 == 0);
      default: rsp_ch.ready <= $urandom_range(0, 1);
    endcase
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_values.size() == 0) begin
        $error("sample_value: unexpected result %h", rsp_ch.data.sample_value);
        fail_count++;
      end else begin
        logic [63:0] want;
        want = pending_values.pop_front();
        if (rsp_ch.data.sample_value !== want) begin
          $error("sample_value: expected %h, actual %h", want,
                 rsp_ch.data.sample_value);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    sample_req_t r;
    logic [1:0]  m;
    logic [63:0] b;
    logic [12:0] c;
    logic [63:0] pk;
    int          idx;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgMode;
    cfg_data = 64'd0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cycle_count = 0;
    fail_count = 0;
    burst_left = 0;
    shadow_mode = ModeUniform;
    shadow_bound = 64'd1;
    shadow_count = 13'd1;

    // Directed table: reset values, bound extremes, search edges, mode aliases
    add_req(sample_req(rand64(), AllOnes), 1, 64'd0);
    add_cfg(CfgBound, 64'd0);
    add_req(sample_req(64'd0, AllOnes), 1, AllOnes);
    add_cfg(CfgBound, 64'd10);
    add_req(sample_req(64'd0, 64'd12345), 1, 64'd5);
    add_req(load_req(12'd0, 64'd100, 64'd10, 64'h4000_0000_0000_0000));
    add_req(load_req(12'd1, 64'd1000, 64'd0, 64'h8000_0000_0000_0000));
    add_req(load_req(12'd2, AllOnes, AllOnes, 64'hC000_0000_0000_0000));
    add_req(load_req(12'd3, 64'd0, 64'd1, AllOnes));
    add_cfg(CfgCount, 64'd4);
    add_cfg(CfgMode, 64'(ModeRank));
    add_req(sample_req(64'd0, 64'd7), 1, 64'd107);
    add_req(sample_req(64'h4000_0000_0000_0000, 64'd9), 1, 64'd1000);
    add_req(sample_req(64'h8000_0000_0000_0000, 64'd3), 1, 64'd2);
    add_req(sample_req(AllOnes, 64'd5), 1, 64'd0);
    add_cfg(CfgMode, 64'hFFFF_0000_0000_0000 | 64'(ModeRankAlt));
    add_req(sample_req(64'd0, 64'd7), 1, 64'd107);
    add_cfg(CfgMode, 64'(ModePermuted));
    add_req(sample_req(64'd0, 64'd0));
    add_cfg(CfgBound, 64'd0);
    add_req(sample_req(64'h7FFF_FFFF_FFFF_FFFF, AllOnes));
    add_cfg(CfgCount, 64'd0);
    add_req(sample_req(AllOnes, 64'd3));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG)
        write_setting(stim_rows[i].cfg_idx, stim_rows[i].cfg_data);
      else
        send_request(stim_rows[i].req, stim_rows[i].has_value, stim_rows[i].value);
    end

    // Fill the low part of the table with ascending thresholds; the last one is all ones
    for (idx = 0; idx < FillDepth; idx++) begin
      send_request(load_req(12'(idx), rand64(), rand_size(),
                            (idx == FillDepth - 1) ? AllOnes
                                                   : {8'(idx), 24'($urandom), $urandom}));
    end

    // Guard entries on the search path of a saturated count keep it in the low part
    for (idx = 2 * FillDepth - 1; idx < TableDepth; idx = 2 * idx + 1) begin
      send_request(load_req(12'(idx), rand64(), rand_size(), AllOnes));
    end

    // Random phases, each with its own register setting
    for (int phase = 0; phase < 10; phase++) begin
      m = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0: b = 64'd0;
        1: b = 64'd1;
        2: b = AllOnes;
        3: b = 64'($urandom_range(2, 100));
        default: b = rand64();
      endcase
      case (phase)
        0: c = 13'd8191;
        1: c = 13'd4096;
        2: c = 13'd5000;
        3: c = 13'd2;
        default: c = 13'($urandom_range(0, FillDepth));
      endcase
      write_setting(CfgMode, {$urandom, 30'($urandom), m});
      write_setting(CfgBound, b);
      write_setting(CfgCount, {51'($urandom), c});
      for (int n = 0; n < 100; n++) begin
        idx = $urandom_range(0, FillDepth - 2);
        if ($urandom_range(0, 9) < 2) begin
          send_request(load_req(12'(idx), rand64(), rand_size(),
                                (shadow_thr[idx] & 64'hFF00_0000_0000_0000)
                                | (rand64() >> 8)));
        end else begin
          pk = ($urandom_range(0, 3) == 0) ? shadow_thr[idx] : rand64();
          // Keep the pick below the guard thresholds
          if (pk == AllOnes) pk = 64'd0;
          r = sample_req(pk, rand64());
          send_request(r);
        end
        if (n == 60 && phase == 5) wait_idle();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* zipf_table_sampler.f */
design/zts_pkg.sv
design/zts_if.sv
design/zts_div.sv
design/zts_datapath.sv
design/zts_ctrl.sv
design/zipf_table_sampler.sv
tb/testbench.sv
